// ----- sv/glu_pkg.sv -----
// ----------------------------------------------------------------------------
// glu_pkg: shared types and constants of the GCD / LCM unit
// Operand and result widths, the divider step count, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package glu_pkg;

    // Operand magnitude width: the magnitude of a 32-bit value fits 32 bits.
    localparam int OpW      = 32;
    localparam int ValueW   = 63;
    localparam int DivSteps = OpW;
    localparam int CntW     = $clog2(DivSteps + 1);

    // Command codes carried by the item.
    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EDIV,
        S_LDIV,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture operands and start Euclid
        logic e_start;   // start divide b / a
        logic l_start;   // start divide |x| / gcd
        logic step;      // one restoring divide step
        logic e_upd;     // b <= a, a <= remainder
        logic mul;       // result <= quotient * |y|
        logic set_gcd;   // result <= b
        logic set_zero;  // result <= 0
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic a_zero;
        logic lcm_zero;
        logic is_lcm;
        logic div_done;
    } t_dp_stat;

    // Magnitude of a two's-complement operand; the most negative value
    // maps onto 2^31, which still fits the unsigned width.
    function automatic logic [OpW-1:0] magnitude(input logic [OpW-1:0] v);
        logic [OpW-1:0] m;
        m = v[OpW-1] ? (~v + {{(OpW-1){1'b0}}, 1'b1}) : v;
        return m;
    endfunction

endpackage

// ----- sv/glu_dpath.sv -----
// ----------------------------------------------------------------------------
// glu_dpath: datapath of the GCD / LCM unit
// Holds the operand magnitudes, the Euclid pair, a shared radix-2 restoring
// divider, one 32x32 multiplier and the result register.
// ----------------------------------------------------------------------------
module glu_dpath
    import glu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic              i_command,
    input  logic [OpW-1:0]    i_x,
    input  logic [OpW-1:0]    i_y,
    output t_dp_stat          o_stat,
    output logic [ValueW-1:0] o_result
);

    logic              r_cmd;
    logic [OpW-1:0]    r_ax;
    logic [OpW-1:0]    r_ay;
    logic [OpW-1:0]    r_a;
    logic [OpW-1:0]    r_b;
    logic [OpW-1:0]    r_rem;
    logic [OpW-1:0]    r_quo;
    logic [OpW-1:0]    r_dvsr;
    logic [CntW-1:0]   r_cnt;
    logic [ValueW-1:0] r_res;

    logic [OpW:0]      shifted;
    logic              fits;
    logic [OpW:0]      diff;
    logic [2*OpW-1:0]  product;

    // One restoring divide step: shift in the next dividend bit and subtract
    // the divisor when it fits.
    always_comb begin
        shifted = {r_rem, r_quo[OpW-1]};
        diff    = shifted - {1'b0, r_dvsr};
        fits    = (shifted >= {1'b0, r_dvsr});
        product = r_quo * r_ay;
    end

    // Step counter of the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.e_start || i_cmd.l_start) begin
            r_cnt <= CntW'(DivSteps);
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - {{(CntW-1){1'b0}}, 1'b1};
        end
    end

    // Operand, Euclid pair and divider registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_ax  <= magnitude(i_x);
            r_ay  <= magnitude(i_y);
            r_a   <= magnitude(i_x);
            r_b   <= magnitude(i_y);
        end else if (i_cmd.e_upd) begin
            r_b <= r_a;
            r_a <= r_rem;
        end

        if (i_cmd.e_start) begin
            r_rem  <= '0;
            r_quo  <= r_b;
            r_dvsr <= r_a;
        end else if (i_cmd.l_start) begin
            r_rem  <= '0;
            r_quo  <= r_ax;
            r_dvsr <= r_b;
        end else if (i_cmd.step) begin
            r_rem <= fits ? diff[OpW-1:0] : shifted[OpW-1:0];
            r_quo <= {r_quo[OpW-2:0], fits};
        end
    end

    // Result register: gcd, zero, or the registered product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_gcd) begin
            r_res <= {{(ValueW-OpW){1'b0}}, r_b};
        end else if (i_cmd.set_zero) begin
            r_res <= '0;
        end else if (i_cmd.mul) begin
            r_res <= product[ValueW-1:0];
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.a_zero   = (r_a == '0);
        o_stat.lcm_zero = (r_ax == '0) || (r_ay == '0);
        o_stat.is_lcm   = (r_cmd == CMD_LCM);
        o_stat.div_done = (r_cnt == '0);
    end

    assign o_result = r_res;

endmodule

// ----- sv/glu_ctrl.sv -----
// ----------------------------------------------------------------------------
// glu_ctrl: controller of the GCD / LCM unit
// Sequences Euclid's remainder loop, the LCM divide and multiply, and the
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module glu_ctrl
    import glu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_ready,
    output logic     o_out_load
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.a_zero) begin
                    o_cmd.e_start = 1'b1;
                    n_state       = S_EDIV;
                end else if (!i_stat.is_lcm) begin
                    o_cmd.set_gcd = 1'b1;
                    n_state       = S_FIN;
                end else if (i_stat.lcm_zero) begin
                    o_cmd.set_zero = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.l_start = 1'b1;
                    n_state       = S_LDIV;
                end
            end
            S_EDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.e_upd = 1'b1;
                    n_state     = S_CHECK;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_LDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_start_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_CHECK))
        else $error("accepted item did not enter the check state");
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDIV && !i_stat.div_done) |=> (r_state == S_EDIV))
        else $error("Euclid divide left before its last step");
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_out_free) |=> (r_state == S_FIN))
        else $error("result dropped while the output register was full");
`endif

endmodule

// ----- sv/gcd_lcm_unit_core.sv -----
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core: GCD or LCM of two signed 32-bit operands
// A GCD result follows k Euclid remainder steps (k at most about 46). Each
// step is a check state, then the divider's 32 radix-2 steps and a final
// done check. LCM adds the divide |x| / gcd and the multiply. One item at a
// time: a new item is taken in the cycle after the result moves to the
// output register. Synchronous active-low reset clears all control.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_core
    import glu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [OpW-1:0]    i_x,
    input  logic [OpW-1:0]    i_y,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ValueW-1:0] o_value
);

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic [ValueW-1:0] result;
    logic              start;
    logic              out_free;
    logic              out_load;
    logic              r_out_valid;
    logic [ValueW-1:0] r_out_value;

    assign start    = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    glu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_ready (o_in_ready),
        .o_out_load (out_load)
    );

    glu_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_command (i_command),
        .i_x       (i_x),
        .i_y       (i_y),
        .o_stat    (dp_stat),
        .o_result  (result)
    );

    // Output register: holds a finished item while the next one is worked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !o_in_ready)
        else $error("input ready while an item is in work");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output register overwritten before it was taken");
    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("loaded result not shown at the output");
`endif

endmodule
